[rtl/core/pst_pkg.sv]
package pst_pkg;

   // Table size and per-tick result limit
   localparam int MAX_TASKS  = 16;
   localparam int RESULT_CAP = 16;

   // Field widths
   localparam int REQ_TYPE_W = 3;
   localparam int REQ_IDX_W  = 4;
   localparam int PERIOD_W   = 8;
   localparam int TIME_W     = 32;
   localparam int DUE_W      = 4;

   // Derived widths
   localparam int TASK_IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TASK_CNT_W = $clog2(MAX_TASKS + 1);
   localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);
   localparam int CMP_W      = (TASK_CNT_W > REQ_IDX_W) ? TASK_CNT_W : REQ_IDX_W;

   // Request tdata layout, lowest bit first
   localparam int IDX_LSB    = 0;
   localparam int PERIOD_LSB = IDX_LSB + REQ_IDX_W;
   localparam int NOW_LSB    = PERIOD_LSB + PERIOD_W;
   localparam int REQ_BITS   = NOW_LSB + TIME_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DUE_W + 7) / 8) * 8;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_ADD        = 3'd0,
      REQ_ENABLE     = 3'd1,
      REQ_DISABLE    = 3'd2,
      REQ_ENABLE_ALL = 3'd3,
      REQ_TICK       = 3'd4
   } req_code_type;

   typedef struct packed {
      req_code_type          kind;
      logic [REQ_IDX_W-1:0]  idx;
      logic [PERIOD_W-1:0]   period;
      logic [TIME_W-1:0]     now;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } back_state_type;

   function automatic logic [CMP_W-1:0] widen_idx(input logic [TASK_IDX_W-1:0] v);
      return CMP_W'(v);
   endfunction

   function automatic logic [CMP_W-1:0] widen_cnt(input logic [TASK_CNT_W-1:0] v);
      return CMP_W'(v);
   endfunction

   // Low bits of a table index as carried on the result channel
   function automatic logic [DUE_W-1:0] due_field(input logic [TASK_IDX_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      return wide[DUE_W-1:0];
   endfunction

endpackage

[rtl/core/periodic_task_scheduler.sv]
// A control request passes through the command queue and then takes effect in the execute stage.
// A tick scans one table entry per cycle while the result side does not stall;
// the scan walks the period and last-run RAMs.
// Other requests are executed in the execute stage while it is idle; the queue holds two.
// Reset (synchronous, active high) empties the table and queue, clears enables and last runs.
module periodic_task_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pst_pkg::REQ_TYPE_W-1:0]   req_tuser,  // req_type
   input  logic [pst_pkg::REQ_DATA_W-1:0]   req_tdata,  // task_index, new_period, now_ms
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pst_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // due_task
   output logic                             rsp_tlast   // last_of_run
);
   import pst_pkg::*;

   logic    push_valid, queue_ready, cmd_valid, cmd_pop;
   cmd_type push_cmd, cmd;

   pst_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .queue_ready (queue_ready),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   pst_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (queue_ready),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_cmd    (cmd)
   );

   pst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/core/pst_ram.sv]
module pst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/pst_front.sv]
module pst_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pst_pkg::REQ_TYPE_W-1:0]   req_tuser,
   input  logic [pst_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             queue_ready,
   output logic                             push_valid,
   output pst_pkg::cmd_type                 push_cmd
);
   import pst_pkg::*;

   logic known;

   // Classify the request kind; unknown kinds are accepted and dropped
   always_comb begin
      unique case (req_code_type'(req_tuser)) inside
         REQ_ADD, REQ_ENABLE, REQ_DISABLE, REQ_ENABLE_ALL, REQ_TICK: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   // Unpack the item into a command
   always_comb begin
      push_cmd.kind   = req_code_type'(req_tuser);
      push_cmd.idx    = req_tdata[IDX_LSB +: REQ_IDX_W];
      push_cmd.period = req_tdata[PERIOD_LSB +: PERIOD_W];
      push_cmd.now    = req_tdata[NOW_LSB +: TIME_W];
   end

   assign req_tready = queue_ready;
   assign push_valid = req_tvalid && known;

endmodule

[rtl/core/pst_cmd_fifo.sv]
module pst_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  pst_pkg::cmd_type push_cmd,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output pst_pkg::cmd_type pop_cmd
);
   import pst_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   cmd_type             entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = fill_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and fill level
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      if (do_push) begin
         entries_in[wr_ptr_ff] = push_cmd;
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/core/pst_back.sv]
module pst_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  pst_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import pst_pkg::*;

   back_state_type          state_ff, state_in;
   logic [TASK_CNT_W-1:0]   count_ff, count_in;
   logic [MAX_TASKS-1:0]    enabled_ff, enabled_in;
   logic [MAX_TASKS-1:0]    lr_valid_ff, lr_valid_in;
   logic [TASK_IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [RES_CNT_W-1:0]    res_cnt_ff, res_cnt_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [TASK_IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic                    out_vld_ff, out_vld_in;
   logic [DUE_W-1:0]        out_task_ff, out_task_in;
   logic                    out_last_ff, out_last_in;

   logic                    per_wr_en, lr_wr_en;
   logic [TASK_IDX_W-1:0]   rd_addr, wr_slot, scan_next;
   logic [PERIOD_W-1:0]     period_q;
   logic [TIME_W-1:0]       lr_q, lr_cur, elapsed;
   logic                    due, out_free, take, advance, last_entry, cap_hit;

   // Period and last-run tables
   pst_ram #(.WIDTH(PERIOD_W), .DEPTH(MAX_TASKS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (wr_slot),
      .wr_data (cmd.period),
      .rd_addr (rd_addr),
      .rd_data (period_q)
   );

   pst_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_last_run_ram (
      .clock   (clock),
      .wr_en   (lr_wr_en),
      .wr_addr (scan_idx_ff),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (lr_q)
   );

   // Due check on the entry whose table data is out of the RAMs
   assign wr_slot    = count_ff[TASK_IDX_W-1:0];
   assign lr_cur     = lr_valid_ff[scan_idx_ff] ? lr_q : '0;
   assign elapsed    = now_ff - lr_cur;
   assign due        = enabled_ff[scan_idx_ff] && (elapsed >= TIME_W'(period_q));
   assign out_free   = !out_vld_ff || rsp_tready;
   assign take       = due && (!pend_vld_ff || out_free);
   assign advance    = !due || take;
   assign last_entry = (widen_idx(scan_idx_ff) + CMP_W'(1)) == widen_cnt(count_ff);
   assign cap_hit    = take && ((res_cnt_ff + RES_CNT_W'(1)) == RES_CNT_W'(RESULT_CAP));
   assign scan_next  = scan_idx_ff + TASK_IDX_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.kind == REQ_TICK && count_ff != '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance && (last_entry || cap_hit)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_pop     = 1'b0;
      per_wr_en   = 1'b0;
      lr_wr_en    = 1'b0;
      rd_addr     = '0;
      count_in    = count_ff;
      enabled_in  = enabled_ff;
      lr_valid_in = lr_valid_ff;
      scan_idx_in = scan_idx_ff;
      now_in      = now_ff;
      res_cnt_in  = res_cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_task_in = out_task_ff;
      out_last_in = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            if (cmd_valid) begin
               unique case (cmd.kind) inside
                  REQ_ADD: begin
                     // append a disabled task with last run zero
                     if (widen_cnt(count_ff) < CMP_W'(MAX_TASKS)) begin
                        per_wr_en            = 1'b1;
                        enabled_in[wr_slot]  = 1'b0;
                        lr_valid_in[wr_slot] = 1'b0;
                        count_in             = count_ff + TASK_CNT_W'(1);
                     end
                  end
                  REQ_ENABLE, REQ_DISABLE: begin
                     for (int i = 0; i < MAX_TASKS; i++) begin
                        if (CMP_W'(cmd.idx) == CMP_W'(i) &&
                            CMP_W'(i) < widen_cnt(count_ff)) begin
                           enabled_in[i] = (cmd.kind == REQ_ENABLE);
                        end
                     end
                  end
                  REQ_ENABLE_ALL: begin
                     for (int i = 0; i < MAX_TASKS; i++) begin
                        if (CMP_W'(i) < widen_cnt(count_ff)) begin
                           enabled_in[i] = 1'b1;
                        end
                     end
                  end
                  REQ_TICK: begin
                     // start a scan at entry zero; rd_addr already points there
                     if (count_ff != '0) begin
                        now_in      = cmd.now;
                        scan_idx_in = '0;
                        res_cnt_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // capture a due task; the one held before it goes out as not last
            if (take) begin
               lr_wr_en                 = 1'b1;
               lr_valid_in[scan_idx_ff] = 1'b1;
               pend_vld_in              = 1'b1;
               pend_idx_in              = scan_idx_ff;
               res_cnt_in               = res_cnt_ff + RES_CNT_W'(1);
               if (pend_vld_ff) begin
                  out_vld_in  = 1'b1;
                  out_task_in = due_field(pend_idx_ff);
                  out_last_in = 1'b0;
               end
            end
            // advance the scan, or hold the read on a stalled entry
            if (!advance) begin
               rd_addr = scan_idx_ff;
            end else if (!(last_entry || cap_hit)) begin
               scan_idx_in = scan_next;
               rd_addr     = scan_next;
            end
         end
         ST_FLUSH: begin
            // release the held task as the last of the run
            if (pend_vld_ff && out_free) begin
               out_vld_in  = 1'b1;
               out_task_in = due_field(pend_idx_ff);
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         enabled_ff  <= '0;
         lr_valid_ff <= '0;
         scan_idx_ff <= '0;
         res_cnt_ff  <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         enabled_ff  <= enabled_in;
         lr_valid_ff <= lr_valid_in;
         scan_idx_ff <= scan_idx_in;
         res_cnt_ff  <= res_cnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      pend_idx_ff <= pend_idx_in;
      out_task_ff <= out_task_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_task_ff);
   assign rsp_tlast  = out_last_ff;

   // A held task never survives past the end of a run
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff)
      else $error("held task left over in idle");

   // The scan stays inside the filled part of the table
   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> widen_idx(scan_idx_ff) < widen_cnt(count_ff))
      else $error("scan index beyond task count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      widen_cnt(count_ff) <= CMP_W'(MAX_TASKS))
      else $error("task count above table size");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_CNT_W'(RESULT_CAP))
      else $error("result count above limit");

   // Flushing a held task shows it as the last item of the run
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH && pend_vld_ff && out_free |=> rsp_tvalid && rsp_tlast)
      else $error("end of run not marked");

endmodule
